/* rtl/rss_pkg.sv */
package rss_pkg;

    localparam int DIM_W      = 13;
    localparam int CENTER_W   = 20;
    localparam int RADIUS_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 3'd0,
        CFG_IMAGE_HEIGHT    = 3'd1,
        CFG_SPHERE_CENTER_X = 3'd2,
        CFG_SPHERE_CENTER_Y = 3'd3,
        CFG_SPHERE_CENTER_Z = 3'd4,
        CFG_SPHERE_RADIUS   = 3'd5
    } cfg_idx_t;

    // pipeline control handed to each arithmetic unit
    typedef struct packed {
        logic advance;
        logic valid;
    } rss_stage_t;

endpackage

/* rtl/rss_div_pipe.sv */
module rss_div_pipe #(
    parameter int NUM_W  = 29,
    parameter int DEN_W  = 13,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rss_pkg::rss_stage_t ctl_in,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid_out,
    output logic [QUO_W-1:0]    quo,
    output logic [SIDE_W-1:0]   side_out
);
    import rss_pkg::*;

    // restoring division, one quotient bit per stage; requires num < den << QUO_W
    logic [DEN_W-1:0]  rem_reg   [0:QUO_W-1];
    logic [QUO_W-1:0]  low_reg   [0:QUO_W-1];
    logic [QUO_W-1:0]  quo_reg   [0:QUO_W-1];
    logic [DEN_W-1:0]  den_reg   [0:QUO_W-1];
    logic [SIDE_W-1:0] side_reg  [0:QUO_W-1];
    logic              valid_reg [0:QUO_W-1];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            logic [DEN_W-1:0]  rem_in;
            logic [QUO_W-1:0]  low_in;
            logic [QUO_W-1:0]  quo_in;
            logic [DEN_W-1:0]  den_in;
            logic [SIDE_W-1:0] side_k;
            logic              valid_in;
            logic [DEN_W:0]    cat;
            logic [DEN_W:0]    diff;
            logic              ge;

            if (k == 0) begin : g_first
                assign rem_in   = DEN_W'(num >> QUO_W);
                assign low_in   = num[QUO_W-1:0];
                assign quo_in   = '0;
                assign den_in   = den;
                assign side_k   = side_in;
                assign valid_in = ctl_in.valid;
            end else begin : g_next
                assign rem_in   = rem_reg[k-1];
                assign low_in   = low_reg[k-1];
                assign quo_in   = quo_reg[k-1];
                assign den_in   = den_reg[k-1];
                assign side_k   = side_reg[k-1];
                assign valid_in = valid_reg[k-1];
            end

            assign cat  = {rem_in, low_in[QUO_W-1]};
            assign ge   = (cat >= {1'b0, den_in});
            assign diff = cat - {1'b0, den_in};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (ctl_in.advance) begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctl_in.advance) begin
                    rem_reg[k]  <= ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
                    low_reg[k]  <= low_in << 1;
                    quo_reg[k]  <= {quo_in[QUO_W-2:0], ge};
                    den_reg[k]  <= den_in;
                    side_reg[k] <= side_k;
                end
            end
        end
    endgenerate

    assign valid_out = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

/* rtl/rss_sqrt_pipe.sv */
module rss_sqrt_pipe #(
    parameter int RAD_W  = 36,
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rss_pkg::rss_stage_t       ctl_in,
    input  logic [RAD_W-1:0]          rad,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      valid_out,
    output logic [RAD_W/2-1:0]        root,
    output logic [SIDE_W-1:0]         side_out
);
    import rss_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // digit-by-digit floor square root, one root bit per stage
    logic [REM_W-1:0]  rem_reg   [0:ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [0:ROOT_W-1];
    logic [SIDE_W-1:0] side_reg  [0:ROOT_W-1];
    logic              valid_reg [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic [REM_W-1:0]  rem_in;
            logic [RAD_W-1:0]  rad_in;
            logic [ROOT_W-1:0] root_in;
            logic [SIDE_W-1:0] side_k;
            logic              valid_in;
            logic [REM_W+1:0]  cat;
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  diff;
            logic              ge;

            if (k == 0) begin : g_first
                assign rem_in   = '0;
                assign rad_in   = rad;
                assign root_in  = '0;
                assign side_k   = side_in;
                assign valid_in = ctl_in.valid;
            end else begin : g_next
                assign rem_in   = rem_reg[k-1];
                assign rad_in   = rad_reg[k-1];
                assign root_in  = root_reg[k-1];
                assign side_k   = side_reg[k-1];
                assign valid_in = valid_reg[k-1];
            end

            assign cat   = {rem_in, rad_in[RAD_W-1 -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign ge    = (cat >= trial);
            assign diff  = cat - trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (ctl_in.advance) begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ctl_in.advance) begin
                    rem_reg[k]  <= ge ? diff[REM_W-1:0] : cat[REM_W-1:0];
                    rad_reg[k]  <= rad_in << 2;
                    root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                    side_reg[k] <= side_k;
                end
            end
        end
    endgenerate

    assign valid_out = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

/* rtl/ray_sphere_pixel_shader_top.sv */
// Ray/sphere pixel shader: one pixel coordinate in, one RGB beat out, one pixel per clock
// sustained unless a full, stalled output buffer holds the pipe. Its depth is set by the
// bit-per-stage u/v divider, the bit-per-stage square root of |d|^2 and the
// bit-per-stage dy/|d| divider, plus the multiply stages. The whole pipe advances
// together; a two-beat output buffer lets it keep accepting while one result waits.
// Sphere registers feed a small free-running chain, so write configuration while idle.
module ray_sphere_pixel_shader_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [COORD_BITS-1:0]          s_pixel_x,
    input  logic [COORD_BITS-1:0]          s_pixel_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_red,
    output logic [7:0]                     m_green,
    output logic [7:0]                     m_blue,
    output logic                           m_sphere_hit
);
    import rss_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int SH_L   = (F >= 16) ? F - 16 : 0;
    localparam int SH_R   = (F < 16) ? 16 - F : 0;
    localparam int OW     = CENTER_W + 1 + SH_L;
    localparam int RR_W   = RADIUS_W + SH_L;
    localparam int UQ_W   = F + 1;
    localparam int D_W    = F + 3;
    localparam int PW     = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
    localparam int HP_W   = OW + D_W;
    localparam int HS_W   = HP_W + 2;
    localparam int H_W    = HS_W - F;
    localparam int DD_W   = 2 * F + 4;
    localparam int A_W    = DD_W - F;
    localparam int CS_W   = 2 * OW + 2;
    localparam int C_W    = CS_W - F + 1;
    localparam int AC_W   = A_W + 1 + C_W;
    localparam int HH_W   = 2 * H_W;
    localparam int DISC_W = ((HH_W > AC_W) ? HH_W : AC_W) + 1;
    localparam int ROOT_W = DD_W / 2;
    localparam int AB_W   = F + 1;
    localparam int K07_W  = F;
    localparam int K255_W = F + 8;
    localparam int BP_W   = AB_W + K255_W;
    localparam int BY_W   = BP_W - 2 * F;

    localparam longint ONE_L  = longint'(1) << F;
    localparam longint K07_L  = (longint'(7) * ONE_L * 2 + 10) / 20;
    localparam longint K255_L = (longint'(25599) * ONE_L * 2 + 100) / 200;
    localparam longint BLUE_L = ((K255_L >> F) > 255) ? 255 : (K255_L >> F);

    localparam logic [K07_W-1:0]  K07    = K07_W'(K07_L);
    localparam logic [K255_W-1:0] K255   = K255_W'(K255_L);
    localparam logic [7:0]        BLUE_B = 8'(BLUE_L);
    localparam logic [D_W-1:0]    ONE_D  = D_W'(ONE_L);
    localparam logic [D_W-1:0]    TWO_D  = D_W'(ONE_L * 2);
    localparam logic [AB_W-1:0]   ONE_A  = AB_W'(ONE_L);
    localparam logic [AB_W:0]     ONE_T  = (AB_W + 1)'(ONE_L);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       hit;
    } pix_t;

    // configuration
    logic [DIM_W-1:0]           width_reg, height_reg;
    logic signed [CENTER_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [RADIUS_W-1:0]        radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(200);
            height_reg <= DIM_W'(100);
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= CENTER_W'(65536);
            radius_reg <= RADIUS_W'(32768);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_IMAGE_WIDTH:     width_reg  <= cfg_wr_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    height_reg <= cfg_wr_data[DIM_W-1:0];
                CFG_SPHERE_CENTER_X: cx_reg     <= $signed(cfg_wr_data[CENTER_W-1:0]);
                CFG_SPHERE_CENTER_Y: cy_reg     <= $signed(cfg_wr_data[CENTER_W-1:0]);
                CFG_SPHERE_CENTER_Z: cz_reg     <= $signed(cfg_wr_data[CENTER_W-1:0]);
                CFG_SPHERE_RADIUS:   radius_reg <= cfg_wr_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // Q.16 to Q.F, truncating toward zero
    function automatic logic signed [OW-1:0] to_f(input logic signed [CENTER_W-1:0] v);
        logic signed [OW-1:0] w;
        w = OW'(v);
        if (v < 0) begin
            w = w + OW'((1 << SH_R) - 1);
        end
        to_f = (w >>> SH_R) <<< SH_L;
    endfunction

    // sphere terms, independent of pixels
    logic signed [OW-1:0]   ox_reg, oy_reg, oz_reg;
    logic [RR_W-1:0]        rf_reg;
    logic signed [2*OW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [2*RR_W-1:0]      rr_reg;
    logic signed [C_W-1:0]  c_reg;
    logic signed [CS_W-1:0] csum;

    assign csum = CS_W'(sqx_reg) + CS_W'(sqy_reg) + CS_W'(sqz_reg);

    always_ff @(posedge aclk) begin
        ox_reg  <= -to_f(cx_reg);
        oy_reg  <= -to_f(cy_reg);
        oz_reg  <= -to_f(cz_reg);
        rf_reg  <= RR_W'(radius_reg >> SH_R) << SH_L;
        sqx_reg <= ox_reg * ox_reg;
        sqy_reg <= oy_reg * oy_reg;
        sqz_reg <= oz_reg * oz_reg;
        rr_reg  <= rf_reg * rf_reg;
        c_reg   <= C_W'(csum >>> F) - C_W'(rr_reg >> F);
    end

    // pipeline control and output buffer
    logic [1:0] cnt_reg, cnt_next;
    pix_t       head_reg, head_next, skid_reg, skid_next, pix;
    logic       ce, push, pop, t4_valid_reg;

    assign ce      = (cnt_reg != 2'd2) || m_ready;
    assign s_ready = ce;
    assign push    = t4_valid_reg && ce;
    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;

    // u, v
    logic [DIM_W-1:0] wdiv, hdiv, pxc, pyc;
    logic [PW-1:0]    px_ext, py_ext;

    assign wdiv   = (width_reg >= DIM_W'(2)) ? width_reg - DIM_W'(1) : DIM_W'(1);
    assign hdiv   = (height_reg >= DIM_W'(2)) ? height_reg - DIM_W'(1) : DIM_W'(1);
    assign px_ext = PW'(s_pixel_x);
    assign py_ext = PW'(s_pixel_y);
    assign pxc    = (px_ext > PW'(wdiv)) ? wdiv : DIM_W'(px_ext);
    assign pyc    = (py_ext > PW'(hdiv)) ? hdiv : DIM_W'(py_ext);

    rss_stage_t       in_ctl;
    logic [UQ_W-1:0]  u_q, v_q;
    logic             uv_valid;

    assign in_ctl.advance = ce;
    assign in_ctl.valid   = s_valid;

    rss_div_pipe #(
        .NUM_W(DIM_W + F), .DEN_W(DIM_W), .QUO_W(UQ_W), .SIDE_W(1)
    ) u_div_u (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(in_ctl),
        .num({pxc, {F{1'b0}}}), .den(wdiv), .side_in(1'b0),
        .valid_out(uv_valid), .quo(u_q), .side_out()
    );

    rss_div_pipe #(
        .NUM_W(DIM_W + F), .DEN_W(DIM_W), .QUO_W(UQ_W), .SIDE_W(1)
    ) u_div_v (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(in_ctl),
        .num({pyc, {F{1'b0}}}), .den(hdiv), .side_in(1'b0),
        .valid_out(), .quo(v_q), .side_out()
    );

    // direction and hit test
    logic                    d_valid_reg, m1_valid_reg, m2_valid_reg, m3_valid_reg, m4_valid_reg;
    logic signed [D_W-1:0]   dx_reg, dy_reg, dy1_reg, dy2_reg, dy3_reg, dy4_reg;
    logic signed [HP_W-1:0]  hx_reg, hy_reg;
    logic signed [2*D_W-1:0] sxx_reg, syy_reg;
    logic signed [HS_W-1:0]  hsum;
    logic signed [H_W-1:0]   h_reg;
    logic [DD_W-1:0]         dd2_reg, dd3_reg, dd4_reg;
    logic signed [HH_W-1:0]  hh_reg;
    logic signed [AC_W-1:0]  ac_reg;
    logic signed [DISC_W-1:0] disc;
    logic                    hit4_reg;

    assign hsum = HS_W'(hx_reg) + HS_W'(hy_reg) + (HS_W'(oz_reg) <<< F);
    assign disc = DISC_W'(hh_reg) - DISC_W'(ac_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg  <= uv_valid;
            m1_valid_reg <= d_valid_reg;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            m4_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg   <= $signed(D_W'({u_q, 2'b00}) - TWO_D);
            dy_reg   <= $signed(D_W'({v_q, 1'b0}) - ONE_D);
            hx_reg   <= ox_reg * dx_reg;
            hy_reg   <= oy_reg * dy_reg;
            sxx_reg  <= dx_reg * dx_reg;
            syy_reg  <= dy_reg * dy_reg;
            dy1_reg  <= dy_reg;
            h_reg    <= H_W'(hsum >>> F);
            dd2_reg  <= DD_W'(sxx_reg) + DD_W'(syy_reg) + (DD_W'(1) << (2 * F));
            dy2_reg  <= dy1_reg;
            hh_reg   <= h_reg * h_reg;
            ac_reg   <= $signed({1'b0, dd2_reg[DD_W-1:F]}) * c_reg;
            dd3_reg  <= dd2_reg;
            dy3_reg  <= dy2_reg;
            hit4_reg <= (disc > 0);
            dd4_reg  <= dd3_reg;
            dy4_reg  <= dy3_reg;
        end
    end

    // |d| and dy/|d|
    rss_stage_t            sq_ctl, nd_ctl;
    logic [ROOT_W-1:0]     len;
    logic [D_W:0]          sq_side;
    logic                  sq_valid, nd_valid;
    logic signed [D_W-1:0] dy_s;
    logic [D_W-1:0]        dy_abs;
    logic [UQ_W-1:0]       ny_q;
    logic [1:0]            nd_side;

    assign sq_ctl.advance = ce;
    assign sq_ctl.valid   = m4_valid_reg;

    rss_sqrt_pipe #(
        .RAD_W(DD_W), .SIDE_W(D_W + 1)
    ) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(sq_ctl),
        .rad(dd4_reg), .side_in({hit4_reg, dy4_reg}),
        .valid_out(sq_valid), .root(len), .side_out(sq_side)
    );

    assign dy_s   = $signed(sq_side[D_W-1:0]);
    assign dy_abs = dy_s[D_W-1] ? D_W'(-dy_s) : D_W'(dy_s);

    assign nd_ctl.advance = ce;
    assign nd_ctl.valid   = sq_valid;

    rss_div_pipe #(
        .NUM_W(2 * F + 1), .DEN_W(ROOT_W), .QUO_W(UQ_W), .SIDE_W(2)
    ) u_div_ny (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(nd_ctl),
        .num({dy_abs[F:0], {F{1'b0}}}), .den(len), .side_in({sq_side[D_W], dy_s[D_W-1]}),
        .valid_out(nd_valid), .quo(ny_q), .side_out(nd_side)
    );

    // sky gradient
    logic                t1_valid_reg, t2_valid_reg, t3_valid_reg;
    logic                hit1_reg, hit2_reg, hit3_reg, hit5_reg;
    logic [AB_W:0]       tsum;
    logic [AB_W-1:0]     t_reg, t2_reg, omt, red2_reg, red3_reg, green3_reg;
    logic [AB_W+K07_W-1:0] gm_reg;
    logic [BP_W-1:0]     rb_reg, gb_reg;
    logic [BY_W-1:0]     rby, gby;

    assign tsum = ONE_T + (nd_side[0] ? -(AB_W + 1)'(ny_q) : (AB_W + 1)'(ny_q));
    assign omt  = ONE_A - t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
        end else if (ce) begin
            t1_valid_reg <= nd_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t_reg      <= tsum[AB_W:1];
            hit1_reg   <= nd_side[1];
            gm_reg     <= omt * K07;
            red2_reg   <= t_reg + (omt >> 1);
            t2_reg     <= t_reg;
            hit2_reg   <= hit1_reg;
            green3_reg <= t2_reg + AB_W'(gm_reg >> F);
            red3_reg   <= red2_reg;
            hit3_reg   <= hit2_reg;
            rb_reg     <= red3_reg * K255;
            gb_reg     <= green3_reg * K255;
            hit5_reg   <= hit3_reg;
        end
    end

    assign rby = BY_W'(rb_reg >> (2 * F));
    assign gby = BY_W'(gb_reg >> (2 * F));

    always_comb begin
        if (hit5_reg) begin
            pix.red   = 8'd255;
            pix.green = 8'd0;
            pix.blue  = 8'd0;
            pix.hit   = 1'b1;
        end else begin
            pix.red   = (rby > BY_W'(255)) ? 8'd255 : rby[7:0];
            pix.green = (gby > BY_W'(255)) ? 8'd255 : gby[7:0];
            pix.blue  = BLUE_B;
            pix.hit   = 1'b0;
        end
    end

    // two-beat output buffer
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        case (cnt_reg)
            2'd0: begin
                if (push) begin
                    head_next = pix;
                    cnt_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = pix;
                end else if (push) begin
                    skid_next = pix;
                    cnt_next  = 2'd2;
                end else if (pop) begin
                    cnt_next  = 2'd0;
                end
            end
            default: begin
                if (pop) begin
                    head_next = skid_reg;
                    if (push) begin
                        skid_next = pix;
                    end else begin
                        cnt_next  = 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_red        = head_reg.red;
    assign m_green      = head_reg.green;
    assign m_blue       = head_reg.blue;
    assign m_sphere_hit = head_reg.hit;

endmodule
